// ----- src/cfgl_pkg.sv -----
// ----------------------------------------------------------------------------
// cfgl_pkg: shared types and constants for the record log scanner
// Slot layout constants, CRC-32 matrix, and the structs passed between units.
// ----------------------------------------------------------------------------
package cfgl_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 2048;
   localparam int unsigned SLOT_LIMIT     = 2048;   // 11-bit slot index
   localparam int unsigned IDX_W          = 11;
   localparam int unsigned PAYLOAD_MAX    = 40;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [31:0] SLOT_MAGIC = 32'h4346_4731;

   localparam logic [3:0] POS_MAGIC = 4'd0;
   localparam logic [3:0] POS_TYPE  = 4'd1;
   localparam logic [3:0] POS_SEQ   = 4'd2;
   localparam logic [3:0] POS_SIZE  = 4'd3;
   localparam logic [3:0] POS_CRC   = 4'd15;

   // configuration register indexes
   localparam logic [1:0] CSR_WANT_TYPE    = 2'd0;
   localparam logic [1:0] CSR_WANT_VERSION = 2'd1;
   localparam logic [1:0] CSR_WANT_SIZE    = 2'd2;

   typedef logic [31:0][31:0] crc_mat_type;

   typedef struct packed {
      logic [15:0] want_type;
      logic [15:0] want_version;
      logic [5:0]  want_size;
   } cfg_type;

   // per-request control from the top level
   typedef struct packed {
      logic take;    // word is consumed by the slot logic
      logic first;   // scan state cleared before this word
      logic finish;  // last word accepted: clear scan state afterward
   } step_type;

   // end-of-slot verdict
   typedef struct packed {
      logic        done;
      logic        valid;
      logic        erased;
      logic [31:0] sequence_val;
      logic [31:0] sequence_inc;
   } slot_done_type;

   typedef struct packed {
      logic             record_found;
      logic [IDX_W-1:0] newest_slot;
      logic [31:0]      newest_sequence;
      logic [31:0]      next_sequence;
      logic             free_found;
      logic [IDX_W-1:0] blank_slot;
   } result_type;

   // 32 reflected shift steps; used only to build the constant matrix
   function automatic logic [31:0] crc_shift32(input logic [31:0] x);
      logic [31:0] c;
      c = x;
      for (int k = 0; k < 32; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic crc_mat_type crc_build();
      crc_mat_type m;
      for (int j = 0; j < 32; j++) begin
         m[j] = crc_shift32(32'(1) << j);
      end
      return m;
   endfunction

   localparam crc_mat_type CRC_MAT = crc_build();

   // CRC register after one word, low byte first: linear map of crc ^ word
   function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
      logic [31:0] x;
      logic [31:0] r;
      x = crc ^ w;
      r = '0;
      for (int j = 0; j < 32; j++) begin
         r = r ^ (CRC_MAT[j] & {32{x[j]}});
      end
      return r;
   endfunction

endpackage

// ----- src/cfgl_slot_eval.sv -----
// ----------------------------------------------------------------------------
// cfgl_slot_eval: per-slot word checker
// Tracks position in the slot, running CRC, header match and erased state.
// ----------------------------------------------------------------------------
module cfgl_slot_eval (
   input  logic                    clock,
   input  logic                    reset,
   input  cfgl_pkg::step_type      step,
   input  cfgl_pkg::cfg_type       cfg,
   input  logic [31:0]             word,
   output cfgl_pkg::slot_done_type slot_done
);

   logic [3:0]  pos_ff, pos_in, pos_eff;
   logic [31:0] crc_ff, crc_in, crc_base;
   logic        hdr_ff, hdr_in;
   logic        erased_ff, erased_in, erased_base;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] seq_inc_ff, seq_inc_in;
   logic        size_ok;

   assign pos_eff     = step.first ? cfgl_pkg::POS_MAGIC : pos_ff;
   assign crc_base    = (pos_eff == cfgl_pkg::POS_MAGIC) ? cfgl_pkg::ALL_ONES : crc_ff;
   assign erased_base = (pos_eff == cfgl_pkg::POS_MAGIC) ? 1'b1 : erased_ff;
   assign size_ok     = (word[15:0] == {10'd0, cfg.want_size}) &&
                        (word[15:0] <= 16'(cfgl_pkg::PAYLOAD_MAX));

   always_comb begin
      crc_in     = (pos_eff == cfgl_pkg::POS_CRC) ? crc_base
                                                  : cfgl_pkg::crc_word(crc_base, word);
      erased_in  = erased_base && (word == cfgl_pkg::ALL_ONES);
      hdr_in     = hdr_ff;
      seq_in     = seq_ff;
      seq_inc_in = seq_inc_ff;
      case (pos_eff)
         cfgl_pkg::POS_MAGIC: hdr_in = (word == cfgl_pkg::SLOT_MAGIC);
         cfgl_pkg::POS_TYPE:  hdr_in = hdr_ff && (word[15:0] == cfg.want_type) &&
                                       (word[31:16] == cfg.want_version);
         cfgl_pkg::POS_SEQ: begin
            seq_in     = word;
            seq_inc_in = word + 32'd1;
         end
         cfgl_pkg::POS_SIZE:  hdr_in = hdr_ff && size_ok;
         default:             hdr_in = hdr_ff;
      endcase
      if (step.finish) begin
         pos_in = cfgl_pkg::POS_MAGIC;
      end else if (step.take) begin
         pos_in = pos_eff + 4'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= cfgl_pkg::POS_MAGIC;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.take) begin
         crc_ff     <= crc_in;
         hdr_ff     <= hdr_in;
         erased_ff  <= erased_in;
         seq_ff     <= seq_in;
         seq_inc_ff <= seq_inc_in;
      end
   end

   assign slot_done.done         = step.take && (pos_eff == cfgl_pkg::POS_CRC);
   assign slot_done.valid        = hdr_ff && (word == ~crc_ff);
   assign slot_done.erased       = erased_in;
   assign slot_done.sequence_val = seq_ff;
   assign slot_done.sequence_inc = seq_inc_ff;

endmodule

// ----- src/cfgl_tracker.sv -----
// ----------------------------------------------------------------------------
// cfgl_tracker: newest-record and first-free-slot tracking
// Keeps the slot counter, best valid record and first erased slot per area.
// ----------------------------------------------------------------------------
module cfgl_tracker #(
   parameter int unsigned SLOT_COUNT = cfgl_pkg::SLOT_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfgl_pkg::step_type      step,
   input  cfgl_pkg::slot_done_type slot_done,
   output logic                    area_full,
   output cfgl_pkg::result_type    result
);

   localparam int unsigned EFF_SLOTS = (SLOT_COUNT > cfgl_pkg::SLOT_LIMIT) ?
                                       cfgl_pkg::SLOT_LIMIT : SLOT_COUNT;
   localparam logic [cfgl_pkg::IDX_W-1:0] LAST_IDX = cfgl_pkg::IDX_W'(EFF_SLOTS - 1);

   logic [cfgl_pkg::IDX_W-1:0] idx_ff, idx_in, idx_eff;
   logic                       full_ff, full_in;
   logic                       have_best_ff, have_best_in, have_best_eff;
   logic [31:0]                best_seq_ff, best_seq_in;
   logic [31:0]                best_inc_ff, best_inc_in;
   logic [cfgl_pkg::IDX_W-1:0] best_slot_ff, best_slot_in;
   logic                       have_free_ff, have_free_in, have_free_eff;
   logic [cfgl_pkg::IDX_W-1:0] blank_slot_ff, blank_slot_in;
   logic [31:0]                diff;
   logic                       newer;

   assign idx_eff       = step.first ? '0 : idx_ff;
   assign have_best_eff = step.first ? 1'b0 : have_best_ff;
   assign have_free_eff = step.first ? 1'b0 : have_free_ff;
   assign area_full     = full_ff;

   assign diff  = slot_done.sequence_val - best_seq_ff;
   assign newer = !have_best_eff || ((diff != 32'd0) && !diff[31]);

   always_comb begin
      idx_in        = idx_eff;
      full_in       = step.first ? 1'b0 : full_ff;
      have_best_in  = have_best_eff;
      best_seq_in   = best_seq_ff;
      best_inc_in   = best_inc_ff;
      best_slot_in  = best_slot_ff;
      have_free_in  = have_free_eff;
      blank_slot_in = blank_slot_ff;
      if (slot_done.done) begin
         if (slot_done.valid && newer) begin
            have_best_in = 1'b1;
            best_seq_in  = slot_done.sequence_val;
            best_inc_in  = slot_done.sequence_inc;
            best_slot_in = idx_eff;
         end
         if (slot_done.erased && !have_free_eff) begin
            have_free_in  = 1'b1;
            blank_slot_in = idx_eff;
         end
         if (idx_eff == LAST_IDX) begin
            full_in = 1'b1;
         end
         idx_in = idx_eff + 1'b1;
      end
   end

   // result as seen after this word
   assign result.record_found    = have_best_in;
   assign result.newest_slot     = have_best_in ? best_slot_in : '0;
   assign result.newest_sequence = have_best_in ? best_seq_in : 32'd0;
   assign result.next_sequence   = have_best_in ? best_inc_in : 32'd1;
   assign result.free_found      = have_free_in;
   assign result.blank_slot      = have_free_in ? blank_slot_in : '0;

   always_ff @(posedge clock) begin
      if (reset || step.finish) begin
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         have_best_ff <= 1'b0;
         have_free_ff <= 1'b0;
      end else if (step.take) begin
         idx_ff       <= idx_in;
         full_ff      <= full_in;
         have_best_ff <= have_best_in;
         have_free_ff <= have_free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.take) begin
         best_seq_ff   <= best_seq_in;
         best_inc_ff   <= best_inc_in;
         best_slot_ff  <= best_slot_in;
         blank_slot_ff <= blank_slot_in;
      end
   end

endmodule

// ----- src/config_record_log_scanner.sv -----
// ----------------------------------------------------------------------------
// config_record_log_scanner: append-only flash record log scanner
// Checks 16-word slots (magic, header, CRC-32), reports newest record and
// first erased slot at the end of each area.
// ----------------------------------------------------------------------------
//  channel | ports                      | role
//  --------+----------------------------+------------------------------------
//  req     | valid/ready, word, marks   | flash words in address order
//  rsp     | valid/ready, six fields    | one result per area, on last word
//  csr     | wen, index, wdata          | want_type/want_version/want_size
//
//  One request per cycle sustained unless the input register stalls. A
//  request is held in the input register, then the slot and tracker logic
//  update state and, on the last word, load the result register that
//  drives rsp_valid.
//  Reset (synchronous) clears scan state and sets want_size to 1.
//  The input register stalls only when it holds a last word and the result
//  register is still full and not being taken; all other words keep flowing
//  under rsp stalls.
// ----------------------------------------------------------------------------
module config_record_log_scanner #(
   parameter int unsigned SLOT_COUNT = cfgl_pkg::SLOT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_flash_word,
   input  logic                       req_first_of_area,
   input  logic                       req_last_of_area,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_record_found,
   output logic [cfgl_pkg::IDX_W-1:0] rsp_newest_slot,
   output logic [31:0]                rsp_newest_sequence,
   output logic [31:0]                rsp_next_sequence,
   output logic                       rsp_free_found,
   output logic [cfgl_pkg::IDX_W-1:0] rsp_blank_slot,
   // configuration
   input  logic                       csr_wen,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);

   cfgl_pkg::cfg_type       cfg_ff;
   cfgl_pkg::step_type      step;
   cfgl_pkg::slot_done_type slot_done;
   cfgl_pkg::result_type    result;
   cfgl_pkg::result_type    rsp_ff;

   logic        in_vld_ff, in_vld_in;
   logic [31:0] in_word_ff;
   logic        in_first_ff, in_last_ff;
   logic        rsp_vld_ff, rsp_vld_in;
   logic        area_full;
   logic        advance;
   logic        req_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.want_type    <= '0;
         cfg_ff.want_version <= '0;
         cfg_ff.want_size    <= 6'd1;
      end else if (csr_wen) begin
         case (csr_index)
            cfgl_pkg::CSR_WANT_TYPE:    cfg_ff.want_type    <= csr_wdata;
            cfgl_pkg::CSR_WANT_VERSION: cfg_ff.want_version <= csr_wdata;
            cfgl_pkg::CSR_WANT_SIZE:    cfg_ff.want_size    <= csr_wdata[5:0];
            default:                    cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // staged request moves on unless it would overwrite a pending result
   assign advance   = in_vld_ff && (!in_last_ff || !rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign in_vld_in = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff  <= req_flash_word;
         in_first_ff <= req_first_of_area;
         in_last_ff  <= req_last_of_area;
      end
   end

   // words past the last countable slot are dropped until the area ends
   assign step.take   = advance && (in_first_ff || !area_full);
   assign step.first  = in_first_ff;
   assign step.finish = advance && in_last_ff;

   cfgl_slot_eval u_slot_eval (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cfg       (cfg_ff),
      .word      (in_word_ff),
      .slot_done (slot_done)
   );

   cfgl_tracker #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .slot_done (slot_done),
      .area_full (area_full),
      .result    (result)
   );

   // result register
   assign rsp_vld_in = step.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.finish) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_record_found    = rsp_ff.record_found;
   assign rsp_newest_slot     = rsp_ff.newest_slot;
   assign rsp_newest_sequence = rsp_ff.newest_sequence;
   assign rsp_next_sequence   = rsp_ff.next_sequence;
   assign rsp_free_found      = rsp_ff.free_found;
   assign rsp_blank_slot      = rsp_ff.blank_slot;

endmodule

// ----- dv/tb_config_record_log_scanner.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_config_record_log_scanner: self-checking bench for the record log scanner
// Streams flash areas built from valid, damaged, erased and noise slots through
// the request channel, predicts each area report in a scoreboard, and checks
// every report field by field under random request gaps and report stalls.
// ----------------------------------------------------------------------------
module tb_config_record_log_scanner;

   localparam int unsigned CYCLE_LIMIT = 600_000;
   localparam int unsigned LONG_HOLD   = 400;
   // slots that the scanner evaluates before it ignores the rest of an area
   localparam int unsigned SLOTS_SCANNED =
      (cfgl_pkg::SLOT_COUNT_DEF > cfgl_pkg::SLOT_LIMIT) ?
      cfgl_pkg::SLOT_LIMIT : cfgl_pkg::SLOT_COUNT_DEF;

   typedef enum int {
      SLOT_RECORD, SLOT_BROKEN, SLOT_ERASED, SLOT_NEAR_ERASED, SLOT_NOISE
   } slot_kind_e;

   // ways to damage an otherwise good record
   typedef enum int {
      BRK_NONE, BRK_MAGIC, BRK_TYPE, BRK_VERSION, BRK_SIZE, BRK_SIZE_HIGH,
      BRK_CRC, BRK_PAYLOAD
   } damage_e;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks scan state per request, queues the area reports
   // -------------------------------------------------------------------------
   class scan_scoreboard;
      logic [15:0]                want_type;
      logic [15:0]                want_version;
      logic [5:0]                 want_size;
      logic [3:0]                 word_pos;
      logic [cfgl_pkg::IDX_W-1:0] slot_index;
      logic [31:0]                crc_reg;
      logic                       header_ok;
      logic [31:0]                slot_seq;
      logic                       all_erased;
      logic                       have_best;
      logic [31:0]                best_seq;
      logic [cfgl_pkg::IDX_W-1:0] best_slot;
      logic                       have_free;
      logic [cfgl_pkg::IDX_W-1:0] first_free;
      logic                       area_full;
      cfgl_pkg::result_type       pending_reports[$];
      int                         mismatches;

      function new();
         want_type    = 16'd0;
         want_version = 16'd0;
         want_size    = 6'd1;
         mismatches   = 0;
         clear_scan();
      endfunction

      function void set_config(logic [15:0] t, logic [15:0] v, logic [5:0] s);
         want_type    = t;
         want_version = v;
         want_size    = s;
      endfunction

      function void clear_scan();
         word_pos   = '0;
         slot_index = '0;
         crc_reg    = cfgl_pkg::ALL_ONES;
         header_ok  = 1'b0;
         slot_seq   = '0;
         all_erased = 1'b1;
         have_best  = 1'b0;
         best_seq   = '0;
         best_slot  = '0;
         have_free  = 1'b0;
         first_free = '0;
         area_full  = 1'b0;
      endfunction

      // reflected CRC-32 register update, one byte at a time, low byte first
      function logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
         for (int b = 0; b < 4; b++) begin
            c = c ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++)
               c = c[0] ? ((c >> 1) ^ cfgl_pkg::CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void absorb_word(logic [31:0] w);
         logic [31:0] diff;
         if (word_pos == cfgl_pkg::POS_MAGIC) begin
            crc_reg    = cfgl_pkg::ALL_ONES;
            header_ok  = (w == cfgl_pkg::SLOT_MAGIC);
            all_erased = 1'b1;
         end
         if (word_pos < cfgl_pkg::POS_CRC)
            crc_reg = crc_step(crc_reg, w);
         if (word_pos == cfgl_pkg::POS_TYPE)
            header_ok = header_ok && (w[15:0] == want_type) && (w[31:16] == want_version);
         if (word_pos == cfgl_pkg::POS_SEQ)
            slot_seq = w;
         if (word_pos == cfgl_pkg::POS_SIZE)
            header_ok = header_ok && (w[15:0] == {10'd0, want_size})
                        && (32'(w[15:0]) <= cfgl_pkg::PAYLOAD_MAX);
         all_erased = all_erased && (w == cfgl_pkg::ALL_ONES);
         if (word_pos != cfgl_pkg::POS_CRC) begin
            word_pos = word_pos + 4'd1;
            return;
         end
         // slot complete
         if (header_ok && w == ~crc_reg) begin
            diff = slot_seq - best_seq;
            if (!have_best || (diff != 32'd0 && !diff[31])) begin
               have_best = 1'b1;
               best_seq  = slot_seq;
               best_slot = slot_index;
            end
         end
         if (all_erased && !have_free) begin
            have_free  = 1'b1;
            first_free = slot_index;
         end
         if (32'(slot_index) + 32'd1 >= SLOTS_SCANNED)
            area_full = 1'b1;
         slot_index = slot_index + 1'b1;
         word_pos   = '0;
      endfunction

      function void note_word(logic [31:0] w, logic is_first, logic is_last);
         cfgl_pkg::result_type r;
         if (is_first)
            clear_scan();
         if (!area_full)
            absorb_word(w);
         if (is_last) begin
            r.record_found    = have_best;
            r.newest_slot     = have_best ? best_slot : '0;
            r.newest_sequence = have_best ? best_seq : 32'd0;
            r.next_sequence   = have_best ? best_seq + 32'd1 : 32'd1;
            r.free_found      = have_free;
            r.blank_slot      = have_free ? first_free : '0;
            pending_reports.push_back(r);
            clear_scan();
         end
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: %s expected %h actual %h",
                        $realtime, name, want, seen);
         end
      endfunction

      function void check_report(cfgl_pkg::result_type seen);
         cfgl_pkg::result_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: report with none expected", $realtime);
            return;
         end
         want = pending_reports.pop_front();
         compare_field("record_found", 32'(want.record_found), 32'(seen.record_found));
         compare_field("newest_slot", 32'(want.newest_slot), 32'(seen.newest_slot));
         compare_field("newest_sequence", want.newest_sequence, seen.newest_sequence);
         compare_field("next_sequence", want.next_sequence, seen.next_sequence);
         compare_field("free_found", 32'(want.free_found), 32'(seen.free_found));
         compare_field("blank_slot", 32'(want.blank_slot), 32'(seen.blank_slot));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals; every input known from time zero
   // -------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [31:0]                req_flash_word = '0;
   logic                       req_first_of_area = 1'b0;
   logic                       req_last_of_area = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_record_found;
   logic [cfgl_pkg::IDX_W-1:0] rsp_newest_slot;
   logic [31:0]                rsp_newest_sequence;
   logic [31:0]                rsp_next_sequence;
   logic                       rsp_free_found;
   logic [cfgl_pkg::IDX_W-1:0] rsp_blank_slot;
   logic                       csr_wen = 1'b0;
   logic [1:0]                 csr_index = cfgl_pkg::CSR_WANT_TYPE;
   logic [15:0]                csr_wdata = '0;

   config_record_log_scanner dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_flash_word      (req_flash_word),
      .req_first_of_area   (req_first_of_area),
      .req_last_of_area    (req_last_of_area),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_record_found    (rsp_record_found),
      .rsp_newest_slot     (rsp_newest_slot),
      .rsp_newest_sequence (rsp_newest_sequence),
      .rsp_next_sequence   (rsp_next_sequence),
      .rsp_free_found      (rsp_free_found),
      .rsp_blank_slot      (rsp_blank_slot),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   scan_scoreboard sb;

   // stimulus-side copy of the live configuration, used to build good records
   logic [15:0] cur_type = 16'd0;
   logic [15:0] cur_version = 16'd0;
   logic [5:0]  cur_size = 6'd1;
   logic [31:0] seq_base = '0;
   logic [31:0] area_q[$];   // words of the area being built
   logic        quiet = 1'b0; // no gaps and no stalls while set
   int          hold_requests = 0;
   int          phase_words = 0;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one 16-word slot; only the first keep words go into the area
   function automatic void push_slot(slot_kind_e kind, damage_e dmg, logic [31:0] sq,
                                     int keep);
      logic [31:0] w[16];
      logic [31:0] c;
      int          n;
      for (int i = 0; i < 16; i++)
         w[i] = (kind == SLOT_NOISE) ? $urandom : cfgl_pkg::ALL_ONES;
      if (kind == SLOT_NEAR_ERASED) begin
         n = $urandom_range(0, 15);
         w[n][$urandom_range(0, 31)] = 1'b0;
      end
      if (kind == SLOT_RECORD || kind == SLOT_BROKEN) begin
         w[cfgl_pkg::POS_MAGIC] = cfgl_pkg::SLOT_MAGIC;
         w[cfgl_pkg::POS_TYPE]  = {cur_version, cur_type};
         w[cfgl_pkg::POS_SEQ]   = sq;
         // upper half of the size word is don't-care
         w[cfgl_pkg::POS_SIZE]  = {16'($urandom), 10'd0, cur_size};
         for (int i = 4; i < 15; i++)
            w[i] = $urandom;
         if (kind == SLOT_BROKEN) begin
            case (dmg)
               BRK_MAGIC:     w[cfgl_pkg::POS_MAGIC][$urandom_range(0, 31)] ^= 1'b1;
               BRK_TYPE:      w[cfgl_pkg::POS_TYPE][$urandom_range(0, 15)] ^= 1'b1;
               BRK_VERSION:   w[cfgl_pkg::POS_TYPE][$urandom_range(16, 31)] ^= 1'b1;
               BRK_SIZE:      w[cfgl_pkg::POS_SIZE][$urandom_range(0, 5)] ^= 1'b1;
               BRK_SIZE_HIGH: w[cfgl_pkg::POS_SIZE][$urandom_range(6, 15)] = 1'b1;
               default: ;
            endcase
         end
         c = cfgl_pkg::ALL_ONES;
         for (int i = 0; i < 15; i++)
            c = sb.crc_step(c, w[i]);
         w[cfgl_pkg::POS_CRC] = ~c;
         // damage after the CRC is sealed
         if (kind == SLOT_BROKEN && dmg == BRK_CRC)
            w[cfgl_pkg::POS_CRC][$urandom_range(0, 31)] ^= 1'b1;
         if (kind == SLOT_BROKEN && dmg == BRK_PAYLOAD)
            w[$urandom_range(4, 14)][$urandom_range(0, 31)] ^= 1'b1;
      end
      for (int i = 0; i < keep; i++)
         area_q.push_back(w[i]);
   endfunction

   function automatic slot_kind_e pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return SLOT_RECORD;
      if (r < 65) return SLOT_BROKEN;
      if (r < 80) return SLOT_ERASED;
      if (r < 88) return SLOT_NEAR_ERASED;
      return SLOT_NOISE;
   endfunction

   // sequences clustered around a base so ties, wraps and half-range jumps occur
   function automatic logic [31:0] pick_seq();
      case ($urandom_range(0, 9))
         6:       return seq_base + 32'h8000_0000 + 32'($urandom_range(0, 1));
         7:       return seq_base - 32'd1;
         8:       return $urandom;
         9:       return ($urandom_range(0, 1) == 1) ? cfgl_pkg::ALL_ONES : 32'd0;
         default: return seq_base + 32'($urandom_range(0, 4));
      endcase
   endfunction

   function automatic logic [15:0] pick_field();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [5:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 6'd0;
      if (r == 1) return 6'($urandom_range(41, 63));
      return 6'($urandom_range(1, 40));
   endfunction

   // one request; valid stays up until the word is taken
   task automatic send_word(logic [31:0] w, logic is_first, logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_flash_word    <= w;
      req_first_of_area <= is_first;
      req_last_of_area  <= is_last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_word(w, is_first, is_last);
      phase_words++;
   endtask

   // send area_q; last word closes the area, mid_first >= 0 restarts it there
   task automatic send_area(logic with_first, int mid_first);
      int n;
      n = area_q.size();
      for (int i = 0; i < n; i++)
         send_word(area_q[i], (i == 0 && with_first) || (i == mid_first), i == n - 1);
      area_q.delete();
   endtask

   // sender pause: all reports back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all three registers on consecutive cycles, only while idle
   task automatic write_config(logic [15:0] t, logic [15:0] v, logic [5:0] s);
      drain();
      csr_wen   <= 1'b1;
      csr_index <= cfgl_pkg::CSR_WANT_TYPE;
      csr_wdata <= t;
      @(posedge clock);
      csr_index <= cfgl_pkg::CSR_WANT_VERSION;
      csr_wdata <= v;
      @(posedge clock);
      csr_index <= cfgl_pkg::CSR_WANT_SIZE;
      csr_wdata <= {10'd0, s};
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_config(t, v, s);
      cur_type    = t;
      cur_version = v;
      cur_size    = s;
   endtask

   task automatic send_random_area();
      int n_slots;
      int tail;
      int mid;
      n_slots  = $urandom_range(0, 4);
      seq_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFE : $urandom;
      for (int i = 0; i < n_slots; i++)
         push_slot(pick_kind(), damage_e'($urandom_range(1, 7)), pick_seq(), 16);
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      if (n_slots == 0 && tail == 0)
         tail = $urandom_range(1, 15);
      if (tail > 0)
         push_slot(pick_kind(), damage_e'($urandom_range(1, 7)), pick_seq(), tail);
      // occasional restart of the scan in the middle of an area
      mid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, area_q.size() - 1) : -1;
      send_area($urandom_range(0, 9) != 0, mid);
   endtask

   // -------------------------------------------------------------------------
   // Report side: check on handshake, random stalls, one long hold on request
   // -------------------------------------------------------------------------
   initial begin
      cfgl_pkg::result_type seen;
      int                   stall_left;
      int                   hold_served;
      stall_left  = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
               seen.record_found    = rsp_record_found;
               seen.newest_slot     = rsp_newest_slot;
               seen.newest_sequence = rsp_newest_sequence;
               seen.next_sequence   = rsp_next_sequence;
               seen.free_found      = rsp_free_found;
               seen.blank_slot      = rsp_blank_slot;
               sb.check_report(seen);
            end
            if (hold_served != hold_requests) begin
               hold_served = hold_requests;
               stall_left  = LONG_HOLD;
            end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
               stall_left = pick_gap();
            end
            if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int areas;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: type 0, version 0, size 1
      push_slot(SLOT_RECORD, BRK_NONE, 32'd5, 16);
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      send_area(1'b1, -1);
      // one-word area, first and last on the same request
      send_word(32'h0000_0000, 1'b1, 1'b1);
      // new area right after a report, no first mark
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      send_area(1'b0, -1);

      // all-ones header fields, largest size
      write_config(16'hFFFF, 16'hFFFF, 6'd40);
      push_slot(SLOT_RECORD, BRK_NONE, 32'hFFFF_FFFF, 16);
      push_slot(SLOT_RECORD, BRK_NONE, 32'd0, 16);         // newer by wraparound
      push_slot(SLOT_RECORD, BRK_NONE, 32'd0, 16);         // tie, earlier slot kept
      push_slot(SLOT_RECORD, BRK_NONE, 32'h8000_0000, 16); // half range, not newer
      push_slot(SLOT_BROKEN, BRK_CRC, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_MAGIC, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_TYPE, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_VERSION, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_SIZE, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_SIZE_HIGH, 32'd1, 16);
      push_slot(SLOT_BROKEN, BRK_PAYLOAD, 32'd1, 16);
      push_slot(SLOT_NEAR_ERASED, BRK_NONE, 32'd0, 16);
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      push_slot(SLOT_RECORD, BRK_NONE, 32'd1, 15);         // partial last slot
      send_area(1'b1, -1);
      // newest at all ones: next sequence wraps to zero
      push_slot(SLOT_NOISE, BRK_NONE, 32'd0, 16);
      push_slot(SLOT_RECORD, BRK_NONE, 32'hFFFF_FFFF, 16);
      send_area(1'b1, -1);
      // first mark mid-area drops the record and realigns slots
      push_slot(SLOT_RECORD, BRK_NONE, 32'd7, 16);
      push_slot(SLOT_NOISE, BRK_NONE, 32'd0, 8);
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      send_area(1'b1, 24);

      // size zero accepted when configured
      write_config(16'h5A3C, 16'h0001, 6'd0);
      push_slot(SLOT_RECORD, BRK_NONE, 32'd3, 16);
      send_area(1'b1, -1);
      // size above the payload limit never valid
      write_config(16'h5A3C, 16'h0001, 6'd41);
      push_slot(SLOT_RECORD, BRK_NONE, 32'd3, 16);
      send_area(1'b1, -1);
      write_config(16'h5A3C, 16'h0001, 6'd63);
      push_slot(SLOT_RECORD, BRK_NONE, 32'd3, 16);
      push_slot(SLOT_ERASED, BRK_NONE, 32'd0, 16);
      send_area(1'b1, -1);

      // random phases, each under its own configuration
      for (int ph = 0; ph < 5; ph++) begin
         write_config(pick_field(), pick_field(), pick_size());
         quiet       = (ph == 2);
         phase_words = 0;
         areas       = 0;
         while (phase_words < 30 || areas < 2) begin
            send_random_area();
            areas++;
         end
      end
      quiet = 1'b0;

      // long report hold while requests keep coming: input backs up
      write_config(16'h00A5, 16'hA500, 6'd8);
      hold_requests++;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 0)
            send_word($urandom, 1'b1, 1'b1);
         else begin
            seq_base = $urandom;
            push_slot(pick_kind(), damage_e'($urandom_range(1, 7)), pick_seq(), 16);
            send_area(1'b1, -1);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
src/cfgl_pkg.sv
src/cfgl_slot_eval.sv
src/cfgl_tracker.sv
src/config_record_log_scanner.sv
dv/tb_config_record_log_scanner.sv
